// File: hw/rtl/brc_pkg.sv
// ----------------------------------------------------------------------------
// brc_pkg
// Shared types and constants of the barometer raw compensation pipeline.
// ----------------------------------------------------------------------------
package brc_pkg;

  typedef struct packed {
    logic [15:0] raw_temp;
    logic [15:0] raw_press;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] temp_fine;
    logic signed [31:0] press_pa;
    logic               status;
  } result_t;

  typedef enum logic [2:0] {
    REG_AC1,
    REG_AC2,
    REG_AC3,
    REG_AC4,
    REG_AC5,
    REG_AC6,
    REG_B_PAIR,
    REG_MC_MD
  } reg_index_t;

  typedef struct packed {
    logic [15:0] ac1;
    logic [15:0] ac2;
    logic [15:0] ac3;
    logic [15:0] ac4;
    logic [15:0] ac5;
    logic [15:0] ac6;
    logic [31:0] b_pair;
    logic [31:0] mc_md;
  } coef_t;

  localparam int TEMP_NUM_W   = 27;
  localparam int TEMP_DEN_W   = 19;
  localparam int PRESS_W      = 32;
  localparam int PIPE_LATENCY = TEMP_NUM_W + PRESS_W + 11;

  localparam int B6_OFFSET  = 4000;
  localparam int B4_BIAS    = 32768;
  localparam int B7_SCALE   = 50000;
  localparam int P_GAIN_SQ  = 3038;
  localparam int P_GAIN_LIN = -7375;
  localparam int P_BIAS     = 3791;
  localparam int TEMP_ROUND = 32767;
  localparam int FINE_BIAS  = 8;

  function automatic logic [31:0] asr32(logic [31:0] v, int n);
    return $unsigned($signed(v) >>> n);
  endfunction

endpackage

// File: hw/rtl/barometer_raw_compensation.sv
// Throughput: one transaction per cycle; busy stays low.
// Two bit-per-stage divider pipelines (27 and 32 stages) set the latency.
// Synchronous reset clears all valid bits and sets coefficients to zero.
// ----------------------------------------------------------------------------
// barometer_raw_compensation
// Temperature and pressure compensation of raw barometer readings.
// ----------------------------------------------------------------------------
module barometer_raw_compensation (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  brc_pkg::sample_t sample,
  output logic             result_valid,
  output brc_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data
);

  localparam int TAG1_W = 16 + 19 + 2;
  localparam int TAG2_W = 32 + 2;

  brc_pkg::coef_t coef;

  brc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  assign busy = 1'b0;

  logic [31:0] ac1_w, ac2_w, ac3_w, b1_w, b2_w;
  logic [15:0] mc;
  logic [15:0] md;
  assign ac1_w = {{16{coef.ac1[15]}}, coef.ac1};
  assign ac2_w = {{16{coef.ac2[15]}}, coef.ac2};
  assign ac3_w = {{16{coef.ac3[15]}}, coef.ac3};
  assign b1_w  = {{16{coef.b_pair[31]}}, coef.b_pair[31:16]};
  assign b2_w  = {{16{coef.b_pair[15]}}, coef.b_pair[15:0]};
  assign mc    = coef.mc_md[31:16];
  assign md    = coef.mc_md[15:0];

  logic s1_vld, s2_vld, s4_vld, s5_vld, s6_vld, s7_vld, s8_vld, s9_vld;
  logic s11_vld, s12_vld;

  logic signed [33:0] s1_prod;
  logic [15:0]        s1_up;
  logic signed [33:0] s1_diff;
  assign s1_diff = 34'($signed({1'b0, sample.raw_temp}) - $signed({1'b0, coef.ac6}));

  logic signed [18:0] s2_t1;
  logic signed [19:0] s2_den;
  logic [15:0]        s2_up;
  logic signed [33:0] s1_adj;
  logic signed [18:0] t1;
  assign s1_adj = s1_prod + (s1_prod < 0 ? 34'(brc_pkg::TEMP_ROUND) : 34'sd0);
  assign t1     = 19'(s1_adj >>> 15);

  logic [brc_pkg::TEMP_NUM_W-1:0] d1_num;
  logic [brc_pkg::TEMP_DEN_W-1:0] d1_den;
  logic [TAG1_W-1:0]              d1_tag;
  logic [19:0]                    den_mag;
  logic [26:0]                    num_s;
  assign num_s   = {mc, 11'b0};
  assign d1_num  = mc[15] ? 27'(-num_s) : num_s;
  assign den_mag = s2_den[19] ? 20'(-s2_den) : s2_den;
  assign d1_den  = den_mag[brc_pkg::TEMP_DEN_W-1:0];
  assign d1_tag  = {s2_up, s2_t1, mc[15] ^ s2_den[19], s2_den == 20'sd0};

  logic                           d1_vld;
  logic [brc_pkg::TEMP_NUM_W-1:0] d1_quo;
  logic [TAG1_W-1:0]              d1_otag;

  brc_div_pipe #(
    .NUM_W (brc_pkg::TEMP_NUM_W),
    .DEN_W (brc_pkg::TEMP_DEN_W),
    .TAG_W (TAG1_W)
  ) u_tdiv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_vld),
    .num       (d1_num),
    .den       (d1_den),
    .tag       (d1_tag),
    .out_valid (d1_vld),
    .quo       (d1_quo),
    .out_tag   (d1_otag)
  );

  logic [31:0] q32, t2, t1_w;
  assign q32  = {5'b0, d1_quo};
  assign t2   = d1_otag[1] ? -q32 : q32;
  assign t1_w = {{13{d1_otag[20]}}, d1_otag[20:2]};

  logic [31:0] s4_b5, s5_b5, s6_b5, s7_b5, s8_b5, s9_b5;
  logic [15:0] s4_up, s5_up, s6_up, s7_up, s8_up;
  logic        s4_err, s5_err, s6_err, s7_err, s8_err, s9_err;
  logic [31:0] s5_b6;
  logic [31:0] s6_sqp, s6_ac2b6, s6_ac3b6;
  logic [31:0] s7_m1, s7_m2, s7_x2, s7_x1c;
  logic [31:0] s8_b3, s8_xs;
  logic [31:0] s9_b4p, s9_b7;
  logic [31:0] sq, x1_s8, x3_s8;
  assign sq    = brc_pkg::asr32(s6_sqp, 12);
  assign x1_s8 = brc_pkg::asr32(s7_m1, 11);
  assign x3_s8 = brc_pkg::asr32(s7_x1c + brc_pkg::asr32(s7_m2, 16) + 32'd2, 2);

  logic [31:0] b4, d2_num;
  logic        big;
  assign b4     = s9_b4p >> 15;
  assign big    = s9_b7[31];
  assign d2_num = big ? s9_b7 : {s9_b7[30:0], 1'b0};

  logic               d2_vld;
  logic [31:0]        d2_quo;
  logic [TAG2_W-1:0]  d2_otag;

  brc_div_pipe #(
    .NUM_W (brc_pkg::PRESS_W),
    .DEN_W (brc_pkg::PRESS_W),
    .TAG_W (TAG2_W)
  ) u_pdiv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s9_vld),
    .num       (d2_num),
    .den       (b4),
    .tag       ({s9_b5, big, s9_err | (b4 == 32'd0)}),
    .out_valid (d2_vld),
    .quo       (d2_quo),
    .out_tag   (d2_otag)
  );

  logic [31:0] p_q, x1_p;
  assign p_q  = d2_otag[1] ? {d2_quo[30:0], 1'b0} : d2_quo;
  assign x1_p = brc_pkg::asr32(p_q, 8);

  logic [31:0] s11_p, s11_pp, s11_m7, s11_b5;
  logic [31:0] s12_p, s12_m3, s12_x2, s12_b5;
  logic        s11_err, s12_err;
  logic [31:0] p_fin;
  assign p_fin = s12_p + brc_pkg::asr32(brc_pkg::asr32(s12_m3, 16) + s12_x2
                 + 32'(brc_pkg::P_BIAS), 4);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld       <= 1'b0;
      s2_vld       <= 1'b0;
      s4_vld       <= 1'b0;
      s5_vld       <= 1'b0;
      s6_vld       <= 1'b0;
      s7_vld       <= 1'b0;
      s8_vld       <= 1'b0;
      s9_vld       <= 1'b0;
      s11_vld      <= 1'b0;
      s12_vld      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_vld       <= start && !busy;
      s2_vld       <= s1_vld;
      s4_vld       <= d1_vld;
      s5_vld       <= s4_vld;
      s6_vld       <= s5_vld;
      s7_vld       <= s6_vld;
      s8_vld       <= s7_vld;
      s9_vld       <= s8_vld;
      s11_vld      <= d2_vld;
      s12_vld      <= s11_vld;
      result_valid <= s12_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_prod  <= s1_diff * $signed({18'b0, coef.ac5});
    s1_up    <= sample.raw_press;

    s2_t1    <= t1;
    s2_den   <= 20'(t1) + 20'($signed(md));
    s2_up    <= s1_up;

    s4_b5    <= t1_w + t2;
    s4_up    <= d1_otag[36:21];
    s4_err   <= d1_otag[0];

    s5_b6    <= s4_b5 - 32'(brc_pkg::B6_OFFSET);
    s5_b5    <= s4_b5;
    s5_up    <= s4_up;
    s5_err   <= s4_err;

    s6_sqp   <= s5_b6 * s5_b6;
    s6_ac2b6 <= ac2_w * s5_b6;
    s6_ac3b6 <= ac3_w * s5_b6;
    s6_b5    <= s5_b5;
    s6_up    <= s5_up;
    s6_err   <= s5_err;

    s7_m1    <= sq * b2_w;
    s7_m2    <= sq * b1_w;
    s7_x2    <= brc_pkg::asr32(s6_ac2b6, 11);
    s7_x1c   <= brc_pkg::asr32(s6_ac3b6, 13);
    s7_b5    <= s6_b5;
    s7_up    <= s6_up;
    s7_err   <= s6_err;

    s8_b3    <= brc_pkg::asr32({ac1_w[29:0], 2'b0} + x1_s8 + s7_x2 + 32'd2, 2);
    s8_xs    <= x3_s8 + 32'(brc_pkg::B4_BIAS);
    s8_b5    <= s7_b5;
    s8_up    <= s7_up;
    s8_err   <= s7_err;

    s9_b4p   <= {16'b0, coef.ac4} * s8_xs;
    s9_b7    <= ({16'b0, s8_up} - s8_b3) * 32'(brc_pkg::B7_SCALE);
    s9_b5    <= s8_b5;
    s9_err   <= s8_err;

    s11_p    <= p_q;
    s11_pp   <= x1_p * x1_p;
    s11_m7   <= 32'(brc_pkg::P_GAIN_LIN) * p_q;
    s11_b5   <= d2_otag[33:2];
    s11_err  <= d2_otag[0];

    s12_p    <= s11_p;
    s12_m3   <= s11_pp * 32'(brc_pkg::P_GAIN_SQ);
    s12_x2   <= brc_pkg::asr32(s11_m7, 16);
    s12_b5   <= s11_b5;
    s12_err  <= s11_err;

    result.status    <= s12_err;
    result.temp_fine <= s12_err ? 32'sd0 : $signed(s12_b5 + 32'(brc_pkg::FINE_BIAS));
    result.press_pa  <= s12_err ? 32'sd0 : $signed(p_fin);
  end

endmodule

// File: hw/rtl/brc_cfg_regs.sv
// ----------------------------------------------------------------------------
// brc_cfg_regs
// Calibration coefficient register file.
// ----------------------------------------------------------------------------
module brc_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [2:0]     cfg_index,
  input  logic [31:0]    cfg_data,
  output brc_pkg::coef_t coef
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (cfg_valid) begin
      unique case (brc_pkg::reg_index_t'(cfg_index))
        brc_pkg::REG_AC1:    coef.ac1 <= cfg_data[15:0];
        brc_pkg::REG_AC2:    coef.ac2 <= cfg_data[15:0];
        brc_pkg::REG_AC3:    coef.ac3 <= cfg_data[15:0];
        brc_pkg::REG_AC4:    coef.ac4 <= cfg_data[15:0];
        brc_pkg::REG_AC5:    coef.ac5 <= cfg_data[15:0];
        brc_pkg::REG_AC6:    coef.ac6 <= cfg_data[15:0];
        brc_pkg::REG_B_PAIR: coef.b_pair <= cfg_data;
        brc_pkg::REG_MC_MD:  coef.mc_md <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/brc_div_pipe.sv
// ----------------------------------------------------------------------------
// brc_div_pipe
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module brc_div_pipe #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 32,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [TAG_W-1:0] tag,
  output logic             out_valid,
  output logic [NUM_W-1:0] quo,
  output logic [TAG_W-1:0] out_tag
);

  logic [NUM_W:0]   vld;
  logic [NUM_W-1:0] nq  [NUM_W+1];
  logic [DEN_W-1:0] rem [NUM_W+1];
  logic [DEN_W-1:0] dn  [NUM_W+1];
  logic [TAG_W-1:0] tg  [NUM_W+1];

  assign vld[0] = in_valid;
  assign nq[0]  = num;
  assign rem[0] = '0;
  assign dn[0]  = den;
  assign tg[0]  = tag;

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           fit;

    assign trial = {rem[k], nq[k][NUM_W-1]};
    assign diff  = trial - {1'b0, dn[k]};
    assign fit   = trial >= {1'b0, dn[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      rem[k+1] <= fit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      nq[k+1]  <= {nq[k][NUM_W-2:0], fit};
      dn[k+1]  <= dn[k];
      tg[k+1]  <= tg[k];
    end
  end

  assign out_valid = vld[NUM_W];
  assign quo       = nq[NUM_W];
  assign out_tag   = tg[NUM_W];

endmodule

// File: hw/rtl/brc_checker.sv
// ----------------------------------------------------------------------------
// brc_checker
// Port-level checks of the compensation pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module brc_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             result_valid,
  input brc_pkg::result_t result
);

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##(brc_pkg::PIPE_LATENCY) result_valid)
    else $error("transaction result missing");

  a_no_spurious: assert property (@(posedge clk)
    result_valid |-> $past(start, brc_pkg::PIPE_LATENCY))
    else $error("result without transaction");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status |-> result.temp_fine == 32'sd0 && result.press_pa == 32'sd0)
    else $error("error result not zeroed");

endmodule

bind barometer_raw_compensation brc_checker u_brc_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);

// File: test/barometer_raw_compensation_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometer_raw_compensation_tb
// Drives raw temperature/pressure pairs and calibration writes into the
// compensation pipeline, predicts every result with an independent fixed-point
// model of the compensation and checks each strobed result field by field.
// ----------------------------------------------------------------------------
module barometer_raw_compensation_tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = brc_pkg::PIPE_LATENCY + 10;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_CFG,
    OP_DRAIN
  } op_kind_t;

  typedef struct {
    op_kind_t            kind;
    brc_pkg::reg_index_t idx;
    logic [31:0]         data;
    brc_pkg::sample_t    smp;
  } op_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  brc_pkg::sample_t sample = '0;
  logic             result_valid;
  brc_pkg::result_t result;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [2:0]       cfg_index = '0;
  logic [31:0]      cfg_data = '0;

  op_t              pending_ops[$];
  brc_pkg::result_t expected_results[$];
  brc_pkg::coef_t   coef_shadow = '0;
  int               errors = 0;
  int               samples_sent = 0;
  int               hold_cycles = 0;
  int               quiet_cycles = 0;

  barometer_raw_compensation i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .sample       (sample),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] shift_arith(logic [31:0] v, int n);
    logic signed [31:0] s;
    s = v;
    return s >>> n;
  endfunction

  function automatic logic [31:0] sext_half(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic brc_pkg::result_t compensate(brc_pkg::sample_t s, brc_pkg::coef_t c);
    logic signed [63:0] ut, ac5, ac6, mc, md, t1, den, t2, b5;
    logic [31:0] b1, b2, ac1, ac2, ac3, ac4, b6, sq, x1, x2, x3, b3, b4, b7, p, prod;
    brc_pkg::result_t r;
    r = '0;
    r.status = 1'b1;
    ut  = {48'b0, s.raw_temp};
    ac5 = {48'b0, c.ac5};
    ac6 = {48'b0, c.ac6};
    mc  = {{48{c.mc_md[31]}}, c.mc_md[31:16]};
    md  = {{48{c.mc_md[15]}}, c.mc_md[15:0]};
    b1  = sext_half(c.b_pair[31:16]);
    b2  = sext_half(c.b_pair[15:0]);
    ac1 = sext_half(c.ac1);
    ac2 = sext_half(c.ac2);
    ac3 = sext_half(c.ac3);
    ac4 = {16'b0, c.ac4};
    t1  = ((ut - ac6) * ac5) / 64'sd32768;
    den = t1 + md;
    if (den == 0) return r;
    t2 = (mc * 64'sd2048) / den;
    b5 = t1 + t2;
    b6 = b5[31:0] - 32'd4000;
    prod = b6 * b6;
    sq = shift_arith(prod, 12);
    prod = sq * b2;
    x1 = shift_arith(prod, 11);
    prod = ac2 * b6;
    x2 = shift_arith(prod, 11);
    x3 = x1 + x2;
    b3 = shift_arith(ac1 * 32'd4 + x3 + 32'd2, 2);
    prod = ac3 * b6;
    x1 = shift_arith(prod, 13);
    prod = sq * b1;
    x2 = shift_arith(prod, 16);
    x3 = shift_arith(x1 + x2 + 32'd2, 2);
    prod = ac4 * (x3 + 32'd32768);
    b4 = prod >> 15;
    if (b4 == 0) return r;
    b7 = ({16'b0, s.raw_press} - b3) * 32'd50000;
    if (b7 < 32'h8000_0000) p = (b7 << 1) / b4;
    else p = (b7 / b4) << 1;
    x1 = shift_arith(p, 8);
    x1 = x1 * x1;
    prod = x1 * 32'd3038;
    x1 = shift_arith(prod, 16);
    prod = 32'hFFFF_E331 * p;
    x2 = shift_arith(prod, 16);
    p = p + shift_arith(x1 + x2 + 32'd3791, 4);
    r.temp_fine = b5[31:0] + 32'd8;
    r.press_pa  = p;
    r.status    = 1'b0;
    return r;
  endfunction

  function automatic brc_pkg::coef_t apply_write(brc_pkg::coef_t c,
                                                 brc_pkg::reg_index_t idx,
                                                 logic [31:0] d);
    case (idx)
      brc_pkg::REG_AC1:    c.ac1 = d[15:0];
      brc_pkg::REG_AC2:    c.ac2 = d[15:0];
      brc_pkg::REG_AC3:    c.ac3 = d[15:0];
      brc_pkg::REG_AC4:    c.ac4 = d[15:0];
      brc_pkg::REG_AC5:    c.ac5 = d[15:0];
      brc_pkg::REG_AC6:    c.ac6 = d[15:0];
      brc_pkg::REG_B_PAIR: c.b_pair = d;
      brc_pkg::REG_MC_MD:  c.mc_md = d;
      default: ;
    endcase
    return c;
  endfunction

  // driver
  always @(posedge clk) begin
    logic     nxt_start, nxt_cfg, offer;
    int       idle_pct;
    op_t      op;
    if (rst) begin
      start     <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      nxt_start = start;
      nxt_cfg   = cfg_valid;
      if (start && !busy) begin
        expected_results.push_back(compensate(sample, coef_shadow));
        samples_sent++;
        nxt_start = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        coef_shadow = apply_write(coef_shadow, brc_pkg::reg_index_t'(cfg_index), cfg_data);
        nxt_cfg = 1'b0;
      end
      if (!nxt_start && !nxt_cfg) begin
        if (hold_cycles > 0) begin
          hold_cycles--;
        end else if (pending_ops.size() > 0) begin
          op = pending_ops[0];
          idle_pct = samples_sent < 420 ? 25 : (samples_sent < 840 ? 72 : 0);
          case (op.kind)
            OP_SAMPLE: begin
              offer = $urandom_range(99) >= idle_pct;
              if (offer) begin
                nxt_start = 1'b1;
                sample <= op.smp;
                void'(pending_ops.pop_front());
              end
            end
            OP_CFG: begin
              nxt_cfg = 1'b1;
              cfg_index <= op.idx;
              cfg_data  <= op.data;
              void'(pending_ops.pop_front());
            end
            default: begin
              if (expected_results.size() == 0) begin
                hold_cycles = SETTLE_CYCLES;
                void'(pending_ops.pop_front());
              end
            end
          endcase
        end
      end
      start     <= nxt_start;
      cfg_valid <= nxt_cfg;
    end
  end

  // monitor
  always @(posedge clk) begin
    brc_pkg::result_t exp_r;
    if (!rst && result_valid) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (result.temp_fine !== exp_r.temp_fine) begin
          $error("temp_fine expected %0d actual %0d", exp_r.temp_fine, result.temp_fine);
          errors++;
        end
        if (result.press_pa !== exp_r.press_pa) begin
          $error("press_pa expected %0d actual %0d", exp_r.press_pa, result.press_pa);
          errors++;
        end
        if (result.status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, result.status);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || result_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_sample(logic [15:0] t, logic [15:0] p);
    op_t op;
    op.kind = OP_SAMPLE;
    op.idx = brc_pkg::REG_AC1;
    op.data = '0;
    op.smp.raw_temp = t;
    op.smp.raw_press = p;
    pending_ops.push_back(op);
  endtask

  task automatic add_cfg(brc_pkg::reg_index_t idx, logic [31:0] d);
    op_t op;
    op.kind = OP_CFG;
    op.idx = idx;
    op.data = d;
    op.smp = '0;
    pending_ops.push_back(op);
  endtask

  task automatic add_drain();
    op_t op;
    op.kind = OP_DRAIN;
    op.idx = brc_pkg::REG_AC1;
    op.data = '0;
    op.smp = '0;
    pending_ops.push_back(op);
  endtask

  task automatic add_coefs(logic [15:0] a1, logic [15:0] a2, logic [15:0] a3,
                           logic [15:0] a4, logic [15:0] a5, logic [15:0] a6,
                           logic [31:0] bp, logic [31:0] mm);
    add_drain();
    add_cfg(brc_pkg::REG_AC1, {16'($urandom_range(65535)), a1});
    add_cfg(brc_pkg::REG_AC2, {16'($urandom_range(65535)), a2});
    add_cfg(brc_pkg::REG_AC3, {16'($urandom_range(65535)), a3});
    add_cfg(brc_pkg::REG_AC4, {16'($urandom_range(65535)), a4});
    add_cfg(brc_pkg::REG_AC5, {16'($urandom_range(65535)), a5});
    add_cfg(brc_pkg::REG_AC6, {16'($urandom_range(65535)), a6});
    add_cfg(brc_pkg::REG_B_PAIR, bp);
    add_cfg(brc_pkg::REG_MC_MD, mm);
  endtask

  task automatic add_random(int n, logic [15:0] ac6);
    int k;
    logic [15:0] t;
    for (k = 0; k < n; k++) begin
      t = $urandom_range(3) == 0 ? ac6 + 16'($urandom_range(512)) - 16'd256
                                 : 16'($urandom);
      add_sample(t, 16'($urandom));
    end
  endtask

  initial begin
    int ph;
    logic [15:0] r6;
    // reset coefficients: temperature divisor is zero
    add_sample(16'h0000, 16'h0000);
    add_sample(16'hFFFF, 16'hFFFF);
    // typical calibration, input extremes and walking bits
    add_coefs(16'd408, -16'sd72, -16'sd14383, 16'd32741, 16'd32757, 16'd23153,
              {16'd6190, 16'd4}, {-16'sd8711, 16'd2868});
    add_sample(16'h0000, 16'h0000);
    add_sample(16'hFFFF, 16'hFFFF);
    add_sample(16'h0000, 16'hFFFF);
    add_sample(16'hFFFF, 16'h0000);
    add_sample(16'd27898, 16'd23843);
    for (int b = 0; b < 16; b += 3) add_sample(16'h1 << b, ~(16'h1 << b));
    // zero pressure divisor
    add_drain();
    add_cfg(brc_pkg::REG_AC4, 32'h0);
    add_sample(16'd27898, 16'd23843);
    add_sample(16'hFFFF, 16'h1234);
    // coefficient extremes
    add_coefs(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              32'h7FFF_7FFF, 32'h7FFF_7FFF);
    add_sample(16'h0000, 16'h0000);
    add_sample(16'hFFFF, 16'hFFFF);
    add_sample(16'h8000, 16'h7FFF);
    add_coefs(16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000,
              32'h8000_8000, 32'h8000_8000);
    add_sample(16'h0000, 16'hFFFF);
    add_sample(16'hFFFF, 16'h0000);
    for (ph = 0; ph < 6; ph++) begin
      r6 = ph % 2 ? 16'($urandom) : 16'd20000 + 16'($urandom_range(8000));
      if (ph % 2)
        add_coefs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), r6, $urandom, $urandom);
      else
        add_coefs(16'($urandom_range(800)), 16'($urandom_range(400)) - 16'd200,
                  16'($urandom_range(2000)) - 16'd15000, 16'd30000 +
                  16'($urandom_range(5000)), 16'd24000 + 16'($urandom_range(9000)),
                  r6, {16'($urandom_range(8000)), 16'($urandom_range(60))},
                  {-16'sd9000 + 16'($urandom_range(2000)), 16'($urandom_range(4000))});
      add_random(205, r6);
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (pending_ops.size() != 0 || expected_results.size() != 0 || hold_cycles != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
